// ===== rtl/ghb_pkg.sv =====
package ghb_pkg;

	localparam int PIX_W         = 8;
	localparam int IMG_W         = 13;
	localparam int HALF_W        = 4;
	localparam int COEF_W        = 16;
	localparam int COEF_BITS     = 16;
	localparam int FRAC_BITS     = COEF_BITS - 2;
	localparam int DATA_W        = 64;
	localparam int ADDR_W        = 5;
	localparam int REG_IDX_W     = 2;
	localparam int MAX_HALF_DEF  = 8;
	localparam int MAX_WIDTH_DEF = 4096;

	// register map, 8 bytes apart
	typedef enum logic [REG_IDX_W-1:0] {
		REG_IMAGE_WIDTH = 2'd0,
		REG_HALF_WIDTH  = 2'd1,
		REG_COEF_0      = 2'd2,
		REG_COEF_1      = 2'd3
	} reg_idx_t;

	localparam logic [IMG_W-1:0]  IMAGE_WIDTH_RST = 13'd4096;
	localparam logic [HALF_W-1:0] HALF_WIDTH_RST  = 4'd3;
	localparam logic [DATA_W-1:0] COEF_0_RST      = 64'd3801305848200;
	localparam logic [DATA_W-1:0] COEF_1_RST      = 64'd0;

	typedef struct packed {
		logic [PIX_W-1:0] in_red;
		logic [PIX_W-1:0] in_green;
		logic [PIX_W-1:0] in_blue;
	} in_word_t;

	typedef struct packed {
		logic [PIX_W-1:0] out_red;
		logic [PIX_W-1:0] out_green;
		logic [PIX_W-1:0] out_blue;
		logic             last_of_run;
		logic             row_done;
	} out_word_t;

	typedef struct packed {
		logic [IMG_W-1:0]  image_width;
		logic [HALF_W-1:0] half_width;
		logic [DATA_W-1:0] coef_0;
		logic [DATA_W-1:0] coef_1;
	} cfg_t;

	typedef struct packed {
		logic accept;
		logic step;
		logic finish;
	} cmd_t;

	typedef struct packed {
		logic has_result;
		logic tap_last;
		logic run_last;
		logic out_busy;
	} status_t;

	// weight of the tap at distance idx; taps past seven weigh zero
	function automatic logic [COEF_W-1:0] tap_weight(input logic [DATA_W-1:0] c0,
			input logic [DATA_W-1:0] c1, input logic [7:0] idx);
		logic [DATA_W-1:0] word;
		word = idx[2] ? c1 : c0;
		if (idx > 8'd7) begin
			tap_weight = '0;
		end else begin
			tap_weight = word[{idx[1:0], 4'b0000} +: COEF_W];
		end
	endfunction

endpackage

// ===== rtl/ghb_regs.sv =====
module ghb_regs (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [ghb_pkg::ADDR_W-1:0]  paddr,
	input  logic [ghb_pkg::DATA_W-1:0]  pwdata,
	output logic [ghb_pkg::DATA_W-1:0]  prdata,
	output logic                        pready,
	output ghb_pkg::cfg_t               cfg
);
	import ghb_pkg::*;

	logic [IMG_W-1:0]  image_width_q;
	logic [HALF_W-1:0] half_width_q;
	logic [DATA_W-1:0] coef_0_q;
	logic [DATA_W-1:0] coef_1_q;
	reg_idx_t          idx;
	logic              wr;

	assign idx    = reg_idx_t'(paddr[ADDR_W-1:3]);
	assign pready = 1'b1;
	assign wr     = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_width_q <= IMAGE_WIDTH_RST;
			half_width_q  <= HALF_WIDTH_RST;
			coef_0_q      <= COEF_0_RST;
			coef_1_q      <= COEF_1_RST;
		end else if (wr) begin
			unique case (idx)
				REG_IMAGE_WIDTH: image_width_q <= pwdata[IMG_W-1:0];
				REG_HALF_WIDTH:  half_width_q  <= pwdata[HALF_W-1:0];
				REG_COEF_0:      coef_0_q      <= pwdata;
				REG_COEF_1:      coef_1_q      <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_IMAGE_WIDTH: prdata = DATA_W'(image_width_q);
			REG_HALF_WIDTH:  prdata = DATA_W'(half_width_q);
			REG_COEF_0:      prdata = coef_0_q;
			REG_COEF_1:      prdata = coef_1_q;
			default:         prdata = '0;
		endcase
	end

	assign cfg = '{image_width: image_width_q, half_width: half_width_q,
			coef_0: coef_0_q, coef_1: coef_1_q};

endmodule

// ===== rtl/ghb_dpath.sv =====
module ghb_dpath #(
	parameter int MAX_HALF  = ghb_pkg::MAX_HALF_DEF,
	parameter int MAX_WIDTH = ghb_pkg::MAX_WIDTH_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  ghb_pkg::cfg_t       cfg,
	input  ghb_pkg::cmd_t       cmd,
	output ghb_pkg::status_t    status,
	input  ghb_pkg::in_word_t   in_word,
	output logic                out_valid,
	input  logic                out_stall,
	output ghb_pkg::out_word_t  out_word
);
	import ghb_pkg::*;

	localparam int WIN_DEPTH = 2 * MAX_HALF - 1;
	localparam int IDX_W     = (WIN_DEPTH > 1) ? $clog2(WIN_DEPTH) : 1;
	localparam int KW        = IDX_W + 2;
	localparam int H_W       = $clog2(MAX_HALF + 1);
	localparam int HC_W      = (H_W > HALF_W) ? H_W : HALF_W;
	localparam int CNT_W     = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
	localparam int CMP_W     = ((CNT_W > IMG_W) ? CNT_W : IMG_W) + 1;
	localparam int PROD_W    = PIX_W + COEF_W;
	localparam int ACC_W     = PROD_W + $clog2(WIN_DEPTH + 1);
	localparam int RND_W     = ACC_W + 1;
	localparam logic [RND_W-1:0] RND_HALF = RND_W'(1) << (FRAC_BITS - 1);

	// pixel window, newest at 0
	in_word_t          win_q [WIN_DEPTH];
	logic [CNT_W-1:0]  col_q;
	logic [IDX_W-1:0]  xs_q;
	logic [IDX_W-1:0]  lag_q;
	logic [IDX_W-1:0]  hm1_q;
	logic              row_end_q;
	logic [IDX_W-1:0]  t_q;
	logic [ACC_W-1:0]  acc_q [3];
	logic              out_valid_q;
	out_word_t         out_word_q;

	logic [CMP_W-1:0]  w_raw, w_one, w_eff, x_ext;
	logic [HC_W-1:0]   h_raw, h_one, h_eff;
	logic [IDX_W-1:0]  hm1_new, xs_new, lag_new;
	logic              row_end;
	logic signed [KW-1:0] k_raw, tap_ofs;
	logic [KW-1:0]     dabs;
	logic [IDX_W-1:0]  k_sel;
	logic [COEF_W-1:0] weight;
	in_word_t          pix;
	logic [PIX_W-1:0]  ch   [3];
	logic [PROD_W-1:0] prod [3];
	logic [RND_W-1:0]  rnd  [3];
	logic [PIX_W-1:0]  sat  [3];
	logic              lag_zero, run_last, tap_last;

	// row geometry from registers, clamped to the supported range
	always_comb begin
		w_raw   = CMP_W'(cfg.image_width);
		w_one   = (w_raw == '0) ? CMP_W'(1) : w_raw;
		w_eff   = (w_one > CMP_W'(MAX_WIDTH)) ? CMP_W'(MAX_WIDTH) : w_one;
		x_ext   = CMP_W'(col_q);
		row_end = x_ext >= (w_eff - CMP_W'(1));
		h_raw   = HC_W'(cfg.half_width);
		h_one   = (h_raw == '0) ? HC_W'(1) : h_raw;
		h_eff   = (h_one > HC_W'(MAX_HALF)) ? HC_W'(MAX_HALF) : h_one;
		hm1_new = IDX_W'(h_eff - HC_W'(1));
		xs_new  = (x_ext > CMP_W'(WIN_DEPTH - 1)) ? IDX_W'(WIN_DEPTH - 1)
				: x_ext[IDX_W-1:0];
		lag_new = (row_end && (x_ext < CMP_W'(hm1_new))) ? x_ext[IDX_W-1:0] : hm1_new;
	end

	// window index of the current tap, with edge replication
	always_comb begin
		k_raw = $signed(KW'(lag_q)) + $signed(KW'(hm1_q)) - $signed(KW'(t_q));
		if (k_raw < 0) begin
			k_sel = '0;
		end else if (k_raw > $signed(KW'(xs_q))) begin
			k_sel = xs_q;
		end else begin
			k_sel = k_raw[IDX_W-1:0];
		end
		tap_ofs = $signed(KW'(t_q)) - $signed(KW'(hm1_q));
		dabs    = (tap_ofs < 0) ? KW'(-tap_ofs) : KW'(tap_ofs);
		weight  = tap_weight(cfg.coef_0, cfg.coef_1, 8'(dabs));
		pix     = win_q[k_sel];
	end

	always_comb begin
		ch[0] = pix.in_red;
		ch[1] = pix.in_green;
		ch[2] = pix.in_blue;
		for (int i = 0; i < 3; i++) begin
			prod[i] = PROD_W'(ch[i]) * PROD_W'(weight);
			rnd[i]  = (RND_W'(acc_q[i]) + RND_HALF) >> FRAC_BITS;
			sat[i]  = (rnd[i] > RND_W'(255)) ? 8'hFF : rnd[i][PIX_W-1:0];
		end
	end

	assign lag_zero = (lag_q == '0);
	assign run_last = !row_end_q || lag_zero;
	assign tap_last = ({1'b0, t_q} == {hm1_q, 1'b0});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q       <= '0;
			t_q         <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.accept) begin
				col_q <= row_end ? '0 : col_q + CNT_W'(1);
			end
			if (cmd.accept || cmd.finish || (cmd.step && tap_last)) begin
				t_q <= '0;
			end else if (cmd.step) begin
				t_q <= t_q + IDX_W'(1);
			end
			if (cmd.finish) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			win_q[0] <= in_word;
			for (int i = 1; i < WIN_DEPTH; i++) begin
				win_q[i] <= win_q[i-1];
			end
			xs_q      <= xs_new;
			lag_q     <= lag_new;
			hm1_q     <= hm1_new;
			row_end_q <= row_end;
		end
		if (cmd.step) begin
			for (int i = 0; i < 3; i++) begin
				acc_q[i] <= (t_q == '0) ? ACC_W'(prod[i]) : acc_q[i] + ACC_W'(prod[i]);
			end
		end
		if (cmd.finish) begin
			out_word_q <= '{out_red: sat[0], out_green: sat[1], out_blue: sat[2],
					last_of_run: run_last, row_done: row_end_q && lag_zero};
			if (!run_last) begin
				lag_q <= lag_q - IDX_W'(1);
			end
		end
	end

	assign status = '{has_result: row_end || (x_ext >= CMP_W'(hm1_new)),
			tap_last: tap_last, run_last: run_last,
			out_busy: out_valid_q && out_stall};

	assign out_valid = out_valid_q;
	assign out_word  = out_word_q;

endmodule

// ===== rtl/ghb_ctrl.sv =====
module ghb_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  ghb_pkg::status_t  status,
	output ghb_pkg::cmd_t     cmd
);
	import ghb_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_ACC  = 3'b010,
		S_FIN  = 3'b100
	} state_t;

	state_t state_q, state_d;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_IDLE: begin
				cmd.accept = in_valid;
				if (in_valid && status.has_result) begin
					state_d = S_ACC;
				end
			end
			S_ACC: begin
				cmd.step = 1'b1;
				if (status.tap_last) begin
					state_d = S_FIN;
				end
			end
			S_FIN: begin
				if (!status.out_busy) begin
					cmd.finish = 1'b1;
					state_d    = status.run_last ? S_IDLE : S_ACC;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign in_stall = (state_q != S_IDLE);

endmodule

// ===== rtl/gaussian_horizontal_blur_rgb_top.sv =====
// channel  | handshake            | payload
// ---------+----------------------+--------------------------------------------
// in       | in_valid / in_stall  | in_word  : in_red, in_green, in_blue
// out      | out_valid / out_stall| out_word : out_red/green/blue, last_of_run, row_done
// config   | psel/penable/pwrite  | paddr (8 bytes per register), pwdata/prdata
//
// An input word is taken while the sequencer is idle. Each result then takes
// 2h-1 taps through the shared 3-channel multiply-accumulate, one tap a cycle,
// then a finish step that rounds and loads the output register. So a word
// gives no result, one result, or n results at a row end (n up to h).
// Output stalls hold the sequencer in the finish step only.
// Reset is asynchronous, active low; the pixel window needs no clearing since
// only pixels of the current row are ever read.
module gaussian_horizontal_blur_rgb_top #(
	parameter int MAX_HALF  = ghb_pkg::MAX_HALF_DEF,
	parameter int MAX_WIDTH = ghb_pkg::MAX_WIDTH_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [ghb_pkg::ADDR_W-1:0]  paddr,
	input  logic [ghb_pkg::DATA_W-1:0]  pwdata,
	output logic [ghb_pkg::DATA_W-1:0]  prdata,
	output logic                        pready,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  ghb_pkg::in_word_t           in_word,
	output logic                        out_valid,
	input  logic                        out_stall,
	output ghb_pkg::out_word_t          out_word
);
	import ghb_pkg::*;

	cfg_t    cfg;
	cmd_t    cmd;
	status_t status;

	// register file; the user must write it only while the block is idle, the block itself does not enforce it
	ghb_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// sequencer: idle -> taps -> finish, repeated for each result of a word
	ghb_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.status   (status),
		.cmd      (cmd)
	);

	// window, column tracking, MAC and output register
	ghb_dpath #(
		.MAX_HALF  (MAX_HALF),
		.MAX_WIDTH (MAX_WIDTH)
	) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.cmd       (cmd),
		.status    (status),
		.in_word   (in_word),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_word  (out_word)
	);

endmodule

// ===== rtl/ghb_checker.sv =====
module ghb_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                in_valid,
	input logic                in_stall,
	input logic                out_valid,
	input logic                out_stall,
	input ghb_pkg::out_word_t  out_word
);
	import ghb_pkg::*;

	// a stalled output word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
			out_valid && out_stall |=> out_valid && $stable(out_word))
		else $error("output word changed under stall");

	// the row's last result always closes the run
	a_row_done_last: assert property (@(posedge clk) disable iff (!arst_n)
			out_valid && out_word.row_done |-> out_word.last_of_run)
		else $error("row_done without last_of_run");

	// while idle nothing new is produced
	a_idle_no_word: assert property (@(posedge clk) disable iff (!arst_n)
			!in_stall && !(out_valid && out_stall) |=> !out_valid)
		else $error("result appeared while idle");

	// input resumes only once the run's final word is up
	a_resume_on_last: assert property (@(posedge clk) disable iff (!arst_n)
			$fell(in_stall) |-> out_valid && out_word.last_of_run)
		else $error("input resumed before final result");

	// a word that is not the last keeps the input held
	a_mid_run_stall: assert property (@(posedge clk) disable iff (!arst_n)
			out_valid && !out_word.last_of_run |-> in_stall || !in_valid && in_stall)
		else $error("input open during a run");

endmodule

bind gaussian_horizontal_blur_rgb_top ghb_checker u_ghb_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_word  (out_word)
);

// ===== bench/ghb_blur_monitor.sv =====
`timescale 1ns / 1ps

module ghb_blur_monitor (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [ghb_pkg::ADDR_W-1:0] paddr,
	input  logic [ghb_pkg::DATA_W-1:0] pwdata,
	input  logic                       pready,
	input  logic                       in_valid,
	input  logic                       in_stall,
	input  ghb_pkg::in_word_t          in_word,
	input  logic                       out_valid,
	input  logic                       out_stall,
	input  ghb_pkg::out_word_t         out_word,
	output int                         fail_count,
	output int                         pending
);
	import ghb_pkg::*;

	localparam int WIN_DEPTH = 2 * MAX_HALF_DEF - 1;

	logic [IMG_W-1:0]  width_reg;
	logic [HALF_W-1:0] half_reg;
	logic [DATA_W-1:0] coef_lo;
	logic [DATA_W-1:0] coef_hi;

	// newest pixel of the row at index 0
	in_word_t  row_pixels [WIN_DEPTH];
	int        next_col;
	out_word_t blurred_q [$];

	function automatic logic [COEF_W-1:0] tap_coef(input int ofs);
		if (ofs < 4) begin
			return coef_lo[16 * ofs +: 16];
		end
		if (ofs < 8) begin
			return coef_hi[16 * (ofs - 4) +: 16];
		end
		return '0;
	endfunction

	function automatic logic [PIX_W-1:0] round_sat(input logic [63:0] acc);
		logic [63:0] v;
		v = (acc + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
		return (v > 64'd255) ? 8'hFF : v[7:0];
	endfunction

	// blur column col of the row whose newest pixel is at column newest
	function automatic out_word_t blurred_pixel(input int col, input int newest, input int h);
		logic [63:0] acc_r, acc_g, acc_b, wt;
		int src, age, d;
		out_word_t px;
		acc_r = '0;
		acc_g = '0;
		acc_b = '0;
		for (d = 1 - h; d <= h - 1; d++) begin
			src = col + d;
			if (src < 0) src = 0;
			if (src > newest) src = newest;
			age = newest - src;
			if (age >= WIN_DEPTH) age = WIN_DEPTH - 1;
			wt = 64'(tap_coef(d < 0 ? -d : d));
			acc_r += 64'(row_pixels[age].in_red) * wt;
			acc_g += 64'(row_pixels[age].in_green) * wt;
			acc_b += 64'(row_pixels[age].in_blue) * wt;
		end
		px = '0;
		px.out_red   = round_sat(acc_r);
		px.out_green = round_sat(acc_g);
		px.out_blue  = round_sat(acc_b);
		return px;
	endfunction

	task automatic check_field(input string name, input int want_v, input int got_v);
		if (want_v != got_v) begin
			$display("%0t: %s expected %0d, got %0d", $time, name, want_v, got_v);
			fail_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : monitor
		int w, h, x, first, c;
		out_word_t px, want;
		if (!arst_n) begin
			width_reg  = IMAGE_WIDTH_RST;
			half_reg   = HALF_WIDTH_RST;
			coef_lo    = COEF_0_RST;
			coef_hi    = COEF_1_RST;
			next_col   = 0;
			fail_count = 0;
			pending    = 0;
			blurred_q.delete();
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (reg_idx_t'(paddr[ADDR_W-1:3]))
					REG_IMAGE_WIDTH: width_reg = pwdata[IMG_W-1:0];
					REG_HALF_WIDTH:  half_reg  = pwdata[HALF_W-1:0];
					REG_COEF_0:      coef_lo   = pwdata;
					REG_COEF_1:      coef_hi   = pwdata;
					default: ;
				endcase
			end

			if (in_valid && !in_stall) begin
				w = int'(width_reg);
				h = int'(half_reg);
				if (w < 1) w = 1;
				if (w > MAX_WIDTH_DEF) w = MAX_WIDTH_DEF;
				if (h < 1) h = 1;
				if (h > MAX_HALF_DEF) h = MAX_HALF_DEF;
				for (int i = WIN_DEPTH - 1; i > 0; i--) row_pixels[i] = row_pixels[i - 1];
				row_pixels[0] = in_word;
				x = next_col;
				if (x < w - 1) begin
					next_col = x + 1;
					if (x >= h - 1) begin
						px = blurred_pixel(x - (h - 1), x, h);
						px.last_of_run = 1'b1;
						blurred_q = {blurred_q, px};
					end
				end else begin
					// row end: flush every column still owed
					next_col = 0;
					first = (x >= h - 1) ? x - (h - 1) : 0;
					for (c = first; c <= x; c++) begin
						px = blurred_pixel(c, x, h);
						px.last_of_run = (c == x);
						px.row_done    = (c == x);
						blurred_q = {blurred_q, px};
					end
				end
			end

			if (out_valid && !out_stall) begin
				if (blurred_q.size() == 0) begin
					$display("%0t: result with none expected: rgb %0d %0d %0d last %0b row %0b",
						$time, out_word.out_red, out_word.out_green, out_word.out_blue,
						out_word.last_of_run, out_word.row_done);
					fail_count++;
				end else begin
					want = blurred_q.pop_front();
					check_field("out_red", want.out_red, out_word.out_red);
					check_field("out_green", want.out_green, out_word.out_green);
					check_field("out_blue", want.out_blue, out_word.out_blue);
					check_field("last_of_run", want.last_of_run, out_word.last_of_run);
					check_field("row_done", want.row_done, out_word.row_done);
				end
			end
			pending = blurred_q.size();
		end
	end

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 1ps

module tb;
	import ghb_pkg::*;

	logic              clk;
	logic              arst_n;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [DATA_W-1:0] pwdata;
	logic [DATA_W-1:0] prdata;
	logic              pready;
	logic              in_valid;
	logic              in_stall;
	in_word_t          in_word;
	logic              out_valid;
	logic              out_stall = 1'b0;
	out_word_t         out_word;

	int fail_count;
	int pending;

	// idle odds per cycle, in percent, for the word source and the result sink
	int gap_pct   = 0;
	int stall_pct = 0;
	int words_sent;
	int phase;
	int goal;

	gaussian_horizontal_blur_rgb_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_word   (in_word),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_word  (out_word)
	);

	// watches config writes and both word channels, predicts every result word
	ghb_blur_monitor blur_mon (
		.clk        (clk),
		.arst_n     (arst_n),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.pready     (pready),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.in_word    (in_word),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_word   (out_word),
		.fail_count (fail_count),
		.pending    (pending)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// hard stop: far above the slowest legal run (h=8 row flushes, long stalls)
	initial begin
		#10_000_000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// sink back-pressure, redrawn every cycle
	always @(negedge clk) begin
		out_stall <= ($urandom_range(99) < stall_pct);
	end

	// channel values: lean on the rails so rounding and clipping get hit
	function automatic logic [PIX_W-1:0] rand_chan();
		case ($urandom_range(9))
			0:       return 8'h00;
			1:       return 8'hFF;
			default: return PIX_W'($urandom_range(255));
		endcase
	endfunction

	function automatic in_word_t rand_pixel();
		in_word_t px;
		px.in_red   = rand_chan();
		px.in_green = rand_chan();
		px.in_blue  = rand_chan();
		return px;
	endfunction

	// four taps per word: full random (saturates), modest taps, all ones, all zero
	function automatic logic [DATA_W-1:0] rand_coef();
		logic [DATA_W-1:0] cw;
		case ($urandom_range(5))
			0: cw = {$urandom, $urandom};
			1: cw = '1;
			2: cw = '0;
			default: begin
				for (int t = 0; t < 4; t++) cw[16 * t +: 16] = 16'($urandom_range(0, 4096));
			end
		endcase
		return cw;
	endfunction

	// all tasks start and end on a falling edge
	task automatic cfg_write(input reg_idx_t idx, input logic [DATA_W-1:0] val);
		psel    <= 1'b1;
		pwrite  <= 1'b1;
		penable <= 1'b0;
		paddr   <= ADDR_W'({idx, 3'b000});
		pwdata  <= val;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(negedge clk);
	endtask

	// one word on the input channel; valid held and payload frozen while stalled
	task automatic push_pixel(input in_word_t px);
		while ($urandom_range(99) < gap_pct) begin
			in_valid <= 1'b0;
			in_word  <= rand_pixel();
			@(negedge clk);
		end
		in_valid <= 1'b1;
		in_word  <= px;
		do @(posedge clk); while (in_stall);
		words_sent++;
		@(negedge clk);
	endtask

	task automatic push_random(input int n);
		repeat (n) push_pixel(rand_pixel());
	endtask

	// wait for every predicted word, then let a trailing no-result word settle
	task automatic drain();
		in_valid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (40) @(negedge clk);
	endtask

	// new register set, then mostly whole rows with random pixels; now and then
	// a broken row, which the next width change cuts short mid-row
	task automatic random_segment();
		int w, h, ew, rows;
		drain();
		case ($urandom_range(9))
			0:       w = 0;
			1:       w = 1;
			2:       w = MAX_WIDTH_DEF;
			3:       w = $urandom_range(MAX_WIDTH_DEF + 1, (1 << IMG_W) - 1);
			default: w = $urandom_range(2, 24);
		endcase
		h = ($urandom_range(4) == 0) ? $urandom_range(0, 15) : $urandom_range(1, MAX_HALF_DEF);
		ew = (w == 0) ? 1 : ((w > MAX_WIDTH_DEF) ? MAX_WIDTH_DEF : w);
		cfg_write(REG_IMAGE_WIDTH, DATA_W'(w));
		if ($urandom_range(1)) cfg_write(REG_HALF_WIDTH, DATA_W'(h));
		if ($urandom_range(1)) cfg_write(REG_COEF_0, rand_coef());
		if ($urandom_range(2) == 0) cfg_write(REG_COEF_1, rand_coef());
		if (ew <= 40) begin
			rows = $urandom_range(1, 3);
			push_random(rows * ew);
			if ($urandom_range(4) == 0) push_random($urandom_range(1, ew));
		end else begin
			// huge rows never finish here; only a prefix goes in
			push_random($urandom_range(1, 30));
		end
	endtask

	initial begin
		arst_n     = 1'b0;
		psel       = 1'b0;
		penable    = 1'b0;
		pwrite     = 1'b0;
		paddr      = '0;
		pwdata     = '0;
		in_valid   = 1'b0;
		in_word    = '0;
		words_sent = 0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// --- directed ---
		// reset registers: W=4096, h=3; first two columns give nothing
		push_pixel(in_word_t'(24'h000000));
		push_pixel(in_word_t'(24'hFFFFFF));
		push_pixel(in_word_t'(24'hFF00A5));
		drain();
		// width shrunk mid-row: next word is already past the row end
		cfg_write(REG_IMAGE_WIDTH, DATA_W'(3));
		push_pixel(rand_pixel());
		drain();
		// h=0 acts as 1, one-pixel rows, tap 0 at max clips to 255
		cfg_write(REG_HALF_WIDTH, DATA_W'(0));
		cfg_write(REG_IMAGE_WIDTH, DATA_W'(1));
		cfg_write(REG_COEF_0, '1);
		push_pixel(in_word_t'(24'hFFFFFF));
		push_pixel(in_word_t'(24'h000000));
		drain();
		// h=15 acts as 8, all eight taps live; width 0 acts as 1
		cfg_write(REG_HALF_WIDTH, DATA_W'(15));
		cfg_write(REG_IMAGE_WIDTH, DATA_W'(0));
		cfg_write(REG_COEF_0, {16'd1480, 16'd2030, 16'd2450, 16'd2610});
		cfg_write(REG_COEF_1, {16'd120, 16'd270, 16'd540, 16'd950});
		push_random(1);
		drain();
		// row shorter than h: silent until the row end flushes all five
		cfg_write(REG_IMAGE_WIDTH, DATA_W'(5));
		push_random(5);
		drain();
		// width above the max acts as 4096; then cut at column 9 for 8 results
		cfg_write(REG_IMAGE_WIDTH, DATA_W'((1 << IMG_W) - 1));
		push_random(9);
		drain();
		cfg_write(REG_IMAGE_WIDTH, DATA_W'(2));
		push_random(1);

		// --- random, three idling profiles ---
		for (phase = 0; phase < 3; phase++) begin
			case (phase)
				0: begin
					gap_pct   <= 18;
					stall_pct <= 53;
				end
				1: begin
					gap_pct   <= 53;
					stall_pct <= 18;
				end
				default: begin
					gap_pct   <= 0;
					stall_pct <= 0;
				end
			endcase
			goal = words_sent + 130;
			while (words_sent < goal) random_segment();
		end
		drain();

		if (fail_count == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule
